// File: hw/rtl/tvfs_pkg.sv
// shared types and constants of the trilinear vector field sampler
package tvfs_pkg;

    localparam int MAX_RES     = 32;
    localparam int FRAC_BITS   = 8;
    localparam int COMP_BITS   = 16;
    localparam int RES_W       = 6;
    localparam int IDX_W       = 15;
    localparam int VOXEL_DEPTH = 1 << IDX_W;
    localparam int POS_W       = 13;
    localparam int CELL_W      = POS_W - FRAC_BITS;
    localparam int FRAC_W      = FRAC_BITS + 1;
    localparam int WXY_W       = 2 * FRAC_BITS + 1;
    localparam int W_W         = 3 * FRAC_BITS + 1;
    localparam int PROD_W      = COMP_BITS + W_W + 1;
    localparam int ACC_W       = PROD_W + 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RES_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_Z = 2'd2;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic                        req_type;
        logic [IDX_W-1:0]            voxel_index;
        logic signed [COMP_BITS-1:0] comp_x;
        logic signed [COMP_BITS-1:0] comp_y;
        logic signed [COMP_BITS-1:0] comp_z;
        logic [POS_W-1:0]            pos_x;
        logic [POS_W-1:0]            pos_y;
        logic [POS_W-1:0]            pos_z;
    } req_t;

    typedef struct packed {
        logic signed [COMP_BITS-1:0] vec_x;
        logic signed [COMP_BITS-1:0] vec_y;
        logic signed [COMP_BITS-1:0] vec_z;
        logic                        outside;
    } rsp_t;

    typedef struct packed {
        logic signed [COMP_BITS-1:0] comp_x;
        logic signed [COMP_BITS-1:0] comp_y;
        logic signed [COMP_BITS-1:0] comp_z;
    } voxel_t;

endpackage

// File: hw/rtl/trilinear_vector_field_sampler.sv
// trilinear vector field sampler: voxel store, corner read sequencer and weighted sum
//
// channel  signals                        dir  beat
// req      req_valid req_stall req        in   one voxel write or one sample position
// rsp      rsp_valid rsp_stall rsp        out  one interpolated vector per sample
// cfg      cfg_valid cfg_ready cfg_index  in   one resolution register write
//          cfg_data
//
// a voxel write goes into the store on accept; a sample inside the grid runs through
// cell and address setup (PREP, ADDR1, ADDR2), the eight corner reads through the
// single-port store (RUN), the multiply-accumulate pipeline drain (DRAIN) and FINISH;
// a sample outside the grid goes from PREP straight to FINISH
// reset sets every resolution to 32 and leaves the voxel store unwritten
// a finished result waits in the rsp register; the block stalls req only while busy
module trilinear_vector_field_sampler
    import tvfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RES_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ADDR1,
        ST_ADDR2,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    localparam logic [FRAC_W-1:0] FULL = FRAC_W'(1 << FRAC_BITS);
    localparam logic [ACC_W-1:0]  HALF = ACC_W'(1) << (3 * FRAC_BITS - 1);

    function automatic logic [RES_W-1:0] eff_res(input logic [RES_W-1:0] r);
        logic [RES_W-1:0] e;
        e = r;
        if (r < RES_W'(2))
            e = RES_W'(2);
        else if (r > RES_W'(MAX_RES))
            e = RES_W'(MAX_RES);
        return e;
    endfunction

    state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic v1_reg, v2_reg, v3_reg;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;
    logic [RES_W-1:0] res_x_reg, res_y_reg, res_z_reg;

    req_t req_reg;
    logic outside_reg;
    logic [CELL_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [FRAC_W-1:0] fx_reg, fy_reg, fz_reg;
    logic [RES_W-1:0] rx_reg, ry_reg;
    logic [2*RES_W-1:0] rxry_reg;
    logic [CELL_W+RES_W:0] zr_reg;
    logic [IDX_W-1:0] base_reg;

    voxel_t voxel_mem [VOXEL_DEPTH];
    voxel_t rd_data_reg, data_d_reg;
    logic mem_wr, mem_rd;
    logic [IDX_W-1:0] mem_addr, corner_addr;

    logic [WXY_W-1:0] wxy_reg;
    logic [FRAC_W-1:0] wz_d_reg;
    logic [W_W-1:0] w_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg, acc_z_reg;
    logic signed [ACC_W-1:0] sum_x, sum_y, sum_z;

    logic req_acc;
    logic [RES_W-1:0] rs_x, rs_y, rs_z;
    logic out_x, out_y, out_z;
    logic [CELL_W-1:0] cell_x, cell_y, cell_z;
    logic [FRAC_W-1:0] wxv, wyv, wzv;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // per-axis effective resolution, outside test and clamped cell
    assign rs_x = eff_res(res_x_reg);
    assign rs_y = eff_res(res_y_reg);
    assign rs_z = eff_res(res_z_reg);
    assign out_x = {1'b0, req_reg.pos_x} > {rs_x - RES_W'(1), FRAC_BITS'(0)};
    assign out_y = {1'b0, req_reg.pos_y} > {rs_y - RES_W'(1), FRAC_BITS'(0)};
    assign out_z = {1'b0, req_reg.pos_z} > {rs_z - RES_W'(1), FRAC_BITS'(0)};

    always_comb
    begin
        cell_x = req_reg.pos_x[POS_W-1:FRAC_BITS];
        cell_y = req_reg.pos_y[POS_W-1:FRAC_BITS];
        cell_z = req_reg.pos_z[POS_W-1:FRAC_BITS];
        if ({1'b0, cell_x} > rs_x - RES_W'(2))
            cell_x = CELL_W'(rs_x - RES_W'(2));
        if ({1'b0, cell_y} > rs_y - RES_W'(2))
            cell_y = CELL_W'(rs_y - RES_W'(2));
        if ({1'b0, cell_z} > rs_z - RES_W'(2))
            cell_z = CELL_W'(rs_z - RES_W'(2));
    end

    // corner address and weights for the corner being issued
    assign corner_addr = base_reg
                       + (cnt_reg[0] ? IDX_W'(1) : IDX_W'(0))
                       + (cnt_reg[1] ? IDX_W'(rx_reg) : IDX_W'(0))
                       + (cnt_reg[2] ? IDX_W'(rxry_reg) : IDX_W'(0));
    assign wxv = cnt_reg[0] ? fx_reg : FULL - fx_reg;
    assign wyv = cnt_reg[1] ? fy_reg : FULL - fy_reg;
    assign wzv = cnt_reg[2] ? fz_reg : FULL - fz_reg;

    assign mem_wr   = req_acc && (req.req_type == REQ_WRITE);
    assign mem_rd   = (state_reg == ST_RUN);
    assign mem_addr = mem_wr ? req.voxel_index : corner_addr;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            voxel_mem[mem_addr] <= '{comp_x: req.comp_x, comp_y: req.comp_y, comp_z: req.comp_z};
        else if (mem_rd)
            rd_data_reg <= voxel_mem[mem_addr];
    end

    // rounding to nearest, half toward plus infinity
    assign sum_x = acc_x_reg + $signed(HALF);
    assign sum_y = acc_y_reg + $signed(HALF);
    assign sum_z = acc_z_reg + $signed(HALF);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && req.req_type == REQ_SAMPLE)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = (out_x || out_y || out_z) ? ST_FINISH : ST_ADDR1;
            end
            ST_ADDR1:
            begin
                state_next = ST_ADDR2;
            end
            ST_ADDR2:
            begin
                cnt_next   = 3'd0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!(v1_reg || v2_reg || v3_reg))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    if (outside_reg)
                    begin
                        rsp_next = '{vec_x: '0, vec_y: '0, vec_z: '0, outside: 1'b1};
                    end
                    else
                    begin
                        rsp_next.vec_x   = sum_x[3*FRAC_BITS +: COMP_BITS];
                        rsp_next.vec_y   = sum_y[3*FRAC_BITS +: COMP_BITS];
                        rsp_next.vec_z   = sum_z[3*FRAC_BITS +: COMP_BITS];
                        rsp_next.outside = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 3'd0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            res_x_reg     <= RES_W'(MAX_RES);
            res_y_reg     <= RES_W'(MAX_RES);
            res_z_reg     <= RES_W'(MAX_RES);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            v1_reg        <= mem_rd;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RES_X: res_x_reg <= cfg_data;
                    CFG_RES_Y: res_y_reg <= cfg_data;
                    CFG_RES_Z: res_z_reg <= cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    // sample datapath
    always_ff @(posedge clk)
    begin
        if (req_acc)
            req_reg <= req;
        if (state_reg == ST_PREP)
        begin
            outside_reg <= out_x || out_y || out_z;
            cx_reg      <= cell_x;
            cy_reg      <= cell_y;
            cz_reg      <= cell_z;
            fx_reg      <= FRAC_W'(req_reg.pos_x - {cell_x, FRAC_BITS'(0)});
            fy_reg      <= FRAC_W'(req_reg.pos_y - {cell_y, FRAC_BITS'(0)});
            fz_reg      <= FRAC_W'(req_reg.pos_z - {cell_z, FRAC_BITS'(0)});
            rx_reg      <= rs_x;
            ry_reg      <= rs_y;
        end
        if (state_reg == ST_ADDR1)
        begin
            rxry_reg <= (2*RES_W)'(rx_reg) * (2*RES_W)'(ry_reg);
            zr_reg   <= (CELL_W+RES_W+1)'(cz_reg) * (CELL_W+RES_W+1)'(ry_reg)
                      + (CELL_W+RES_W+1)'(cy_reg);
        end
        if (state_reg == ST_ADDR2)
        begin
            base_reg  <= IDX_W'(IDX_W'(zr_reg) * IDX_W'(rx_reg) + IDX_W'(cx_reg));
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
        end
        if (mem_rd)
        begin
            wxy_reg  <= WXY_W'(wxv) * WXY_W'(wyv);
            wz_d_reg <= wzv;
        end
        if (v1_reg)
        begin
            w_reg      <= W_W'(wxy_reg) * W_W'(wz_d_reg);
            data_d_reg <= rd_data_reg;
        end
        if (v2_reg)
        begin
            prod_x_reg <= $signed(data_d_reg.comp_x) * $signed({1'b0, w_reg});
            prod_y_reg <= $signed(data_d_reg.comp_y) * $signed({1'b0, w_reg});
            prod_z_reg <= $signed(data_d_reg.comp_z) * $signed({1'b0, w_reg});
        end
        if (v3_reg)
        begin
            acc_x_reg <= acc_x_reg + ACC_W'(prod_x_reg);
            acc_y_reg <= acc_y_reg + ACC_W'(prod_y_reg);
            acc_z_reg <= acc_z_reg + ACC_W'(prod_z_reg);
        end
    end

endmodule
